// ===== rtl/ppu_pkg.sv =====
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types, sizes and arithmetic helpers for the particle pool.
// ----------------------------------------------------------------------------
package ppu_pkg;

   localparam int PARTICLES = 64;
   localparam int SLOT_W    = 6;

   localparam logic [16:0] ONE_Q16       = 17'd65536;
   localparam logic [11:0] FADE_RESET    = 12'd640;
   localparam logic [15:0] VSCALE_RESET  = 16'd6554;

   localparam logic CSR_FADE_RATE = 1'b0;
   localparam logic CSR_VSCALE    = 1'b1;

   localparam logic FUNC_SPAWN = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LOAD,
      ST_TICK
   } state_type;

   typedef struct packed {
      logic [16:0]        life;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] vel_x;
      logic signed [23:0] vel_y;
      logic [15:0]        shade;
      logic [16:0]        alpha;
   } particle_type;

   function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
      logic signed [23:0] r;
      if (v > 26'sd8388607)
         r = 24'sd8388607;
      else if (v < -26'sd8388608)
         r = -24'sd8388608;
      else
         r = v[23:0];
      return r;
   endfunction

endpackage

// ===== rtl/ppu_cell.sv =====
// ----------------------------------------------------------------------------
// ppu_cell
// One particle slot of the ring: shifts toward its neighbor or loads a spawn.
// ----------------------------------------------------------------------------
module ppu_cell
   import ppu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         shift_en,
   input  particle_type shift_in,
   input  logic         load_en,
   input  particle_type load_in,
   output particle_type cell_out
);

   particle_type data_ff, data_in;
   logic [16:0]  life_ff;

   always_comb begin
      data_in = data_ff;
      if (load_en) begin
         data_in = load_in;
      end else if (shift_en) begin
         data_in = shift_in;
      end
   end

   // life is the only field that must reset: every slot starts dead
   always_ff @(posedge clock) begin
      if (reset) begin
         life_ff <= '0;
      end else begin
         life_ff <= data_in.life;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      cell_out      = data_ff;
      cell_out.life = life_ff;
   end

endmodule

// ===== rtl/ppu_tick_unit.sv =====
// ----------------------------------------------------------------------------
// ppu_tick_unit
// Ages the particle leaving the head of the ring by one time step.
// ----------------------------------------------------------------------------
module ppu_tick_unit
   import ppu_pkg::*;
(
   input  logic         enable,
   input  logic [15:0]  dt,
   input  logic [19:0]  loss,
   input  particle_type p_in,
   output particle_type p_out
);

   logic [16:0]        life_n;
   logic signed [40:0] prod_x, prod_y;
   logic signed [40:0] rnd_x, rnd_y;
   logic signed [25:0] diff_x, diff_y;

   always_comb begin
      life_n = (p_in.life > {1'b0, dt}) ? p_in.life - {1'b0, dt} : '0;
      prod_x = 41'(p_in.vel_x) * 41'(signed'({1'b0, dt}));
      prod_y = 41'(p_in.vel_y) * 41'(signed'({1'b0, dt}));
      rnd_x  = (prod_x + 41'sd32768) >>> 16;
      rnd_y  = (prod_y + 41'sd32768) >>> 16;
      diff_x = 26'(p_in.pos_x) - rnd_x[25:0];
      diff_y = 26'(p_in.pos_y) - rnd_y[25:0];

      p_out = p_in;
      if (enable) begin
         p_out.life = life_n;
         if (life_n != '0) begin
            p_out.pos_x = sat24(diff_x);
            p_out.pos_y = sat24(diff_y);
            p_out.alpha = ({3'b0, p_in.alpha} > loss) ? p_in.alpha - loss[16:0] : '0;
         end
      end
   end

endmodule

// ===== rtl/particle_pool_update.sv =====
// ----------------------------------------------------------------------------
// particle_pool_update
// Particle pool with round-robin respawn and per-tick aging.
// ----------------------------------------------------------------------------
// The slots live in a ring of PARTICLES cells that, while a tick or a spawn
// scan runs, rotates one place per cycle past a single aging unit. A tick puts
// one item on rsp_* per cycle, slot 0 first, each in the cycle after its
// step; the last carries rsp_last. A spawn rotates the ring once to find a
// dead slot, loads it in the load state and reports it in the cycle after.
// busy is high from the accepting edge through the tick state, or through the
// scan and load states on a spawn; the final item of the work shows in the
// first cycle with busy low, when the next item can already be accepted.
// rsp_* cannot be stalled.
module particle_pool_update
   import ppu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_func,
   input  logic [15:0]         req_dt,
   input  logic signed [23:0]  req_emit_x,
   input  logic signed [23:0]  req_emit_y,
   input  logic signed [23:0]  req_speed_x,
   input  logic signed [23:0]  req_speed_y,
   input  logic signed [23:0]  req_shift_x,
   input  logic signed [23:0]  req_shift_y,
   input  logic [6:0]          req_jitter_code,
   input  logic [6:0]          req_shade_code,
   output logic                rsp_valid,
   output logic [5:0]          rsp_slot,
   output logic                rsp_alive,
   output logic signed [23:0]  rsp_out_x,
   output logic signed [23:0]  rsp_out_y,
   output logic [15:0]         rsp_shade,
   output logic [16:0]         rsp_opacity,
   output logic                rsp_last,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [15:0]         csr_data
);

   state_type state_ff, state_in;
   logic [SLOT_W-1:0] count_ff, count_in;
   logic [SLOT_W-1:0] search_ff, search_in;
   logic [SLOT_W-1:0] hi_ff, hi_in, any_ff, any_in;
   logic              found_hi_ff, found_hi_in, found_any_ff, found_any_in;
   logic [11:0]       fade_ff;
   logic [15:0]       vscale_ff;

   // item registers
   logic [15:0]        dt_ff;
   logic [19:0]        loss_ff;
   logic signed [23:0] emit_x_ff, emit_y_ff, speed_x_ff, speed_y_ff;
   logic signed [23:0] shift_x_ff, shift_y_ff;
   logic [6:0]         jc_ff, sc_ff;
   particle_type       spawn_ff;

   particle_type cells [PARTICLES];
   particle_type head_next;
   logic         shift_en, tick_en, load_en;
   logic [SLOT_W-1:0] pick;

   logic [27:0]  loss_prod;
   logic [14:0]  jn;
   logic [30:0]  jq;
   logic signed [25:0] sum_x, sum_y;
   logic signed [40:0] vp_x, vp_y;
   logic [13:0]  sn;
   logic [27:0]  sq;

   logic         rsp_valid_in;
   particle_type rsp_p_in;
   logic [SLOT_W-1:0] rsp_slot_in;
   logic         rsp_last_in;

   assign busy = (state_ff != ST_IDLE);
   assign pick = found_hi_ff ? hi_ff : (found_any_ff ? any_ff : '0);

   // ring of cells
   for (genvar g = 0; g < PARTICLES; g++) begin : g_ring
      particle_type sin;
      if (g == PARTICLES - 1) begin : g_tail
         assign sin = head_next;
      end else begin : g_mid
         assign sin = cells[g+1];
      end
      ppu_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .shift_in (sin),
         .load_en  (load_en && (pick == SLOT_W'(g))),
         .load_in  (spawn_ff),
         .cell_out (cells[g])
      );
   end

   ppu_tick_unit u_tick (
      .enable (tick_en),
      .dt     (dt_ff),
      .loss   (loss_ff),
      .p_in   (cells[0]),
      .p_out  (head_next)
   );

   // spawn values, built during the scan from the held item
   always_comb begin
      jn    = {jc_ff, 8'd0} + 15'd5;
      jq    = 31'(jn) * 31'd52429;               // /10
      sum_x = 26'(emit_x_ff) + 26'(shift_x_ff) + 26'(jq[30:19]) - 26'sd1280;
      sum_y = 26'(emit_y_ff) + 26'(shift_y_ff) + 26'(jq[30:19]) - 26'sd1280;
      vp_x  = (41'(speed_x_ff) * 41'(signed'({1'b0, vscale_ff})) + 41'sd32768) >>> 16;
      vp_y  = (41'(speed_y_ff) * 41'(signed'({1'b0, vscale_ff})) + 41'sd32768) >>> 16;
      sn    = 14'(sc_ff) * 14'd68 + 14'd50;
      sq    = 28'(sn) * 28'd5243;                // /100
   end

   always_ff @(posedge clock) begin
      spawn_ff.life  <= ONE_Q16;
      spawn_ff.pos_x <= sat24(sum_x);
      spawn_ff.pos_y <= sat24(sum_y);
      spawn_ff.vel_x <= vp_x[23:0];
      spawn_ff.vel_y <= vp_y[23:0];
      spawn_ff.shade <= 16'd16384 + 16'(sc_ff) * 16'd327 + 16'(sq[27:19]);
      spawn_ff.alpha <= ONE_Q16;
   end

   assign loss_prod = 28'(req_dt) * 28'(fade_ff) + 28'd128;

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         dt_ff      <= req_dt;
         loss_ff    <= loss_prod[27:8];
         emit_x_ff  <= req_emit_x;
         emit_y_ff  <= req_emit_y;
         speed_x_ff <= req_speed_x;
         speed_y_ff <= req_speed_y;
         shift_x_ff <= req_shift_x;
         shift_y_ff <= req_shift_y;
         jc_ff      <= req_jitter_code;
         sc_ff      <= req_shade_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_ff   <= FADE_RESET;
         vscale_ff <= VSCALE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FADE_RATE: fade_ff   <= csr_data[11:0];
            CSR_VSCALE:    vscale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         search_ff    <= '0;
         hi_ff        <= '0;
         any_ff       <= '0;
         found_hi_ff  <= 1'b0;
         found_any_ff <= 1'b0;
         rsp_valid    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         search_ff    <= search_in;
         hi_ff        <= hi_in;
         any_ff       <= any_in;
         found_hi_ff  <= found_hi_in;
         found_any_ff <= found_any_in;
         rsp_valid    <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      search_in    = search_ff;
      hi_in        = hi_ff;
      any_in       = any_ff;
      found_hi_in  = found_hi_ff;
      found_any_in = found_any_ff;
      shift_en     = 1'b0;
      tick_en      = 1'b0;
      load_en      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_p_in     = head_next;
      rsp_slot_in  = count_ff;
      rsp_last_in  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            count_in = '0;
            if (start) begin
               found_hi_in  = 1'b0;
               found_any_in = 1'b0;
               state_in     = (req_func == FUNC_TICK) ? ST_TICK : ST_SCAN;
            end
         end
         ST_SCAN: begin
            shift_en = 1'b1;
            // head holds slot count_ff; keep first dead at or after the start
            // and first dead overall for the wrap-around case
            if (cells[0].life == '0) begin
               if (!found_hi_ff && count_ff >= search_ff) begin
                  found_hi_in = 1'b1;
                  hi_in       = count_ff;
               end
               if (!found_any_ff) begin
                  found_any_in = 1'b1;
                  any_in       = count_ff;
               end
            end
            count_in = count_ff + 1'b1;
            if (count_ff == SLOT_W'(PARTICLES - 1)) begin
               count_in = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            load_en      = 1'b1;
            search_in    = pick;
            rsp_valid_in = 1'b1;
            rsp_p_in     = spawn_ff;
            rsp_slot_in  = pick;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_TICK: begin
            shift_en     = 1'b1;
            tick_en      = 1'b1;
            rsp_valid_in = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == SLOT_W'(PARTICLES - 1)) begin
               rsp_last_in = 1'b1;
               count_in    = '0;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_slot  <= rsp_slot_in;
         rsp_last  <= rsp_last_in;
         rsp_alive <= (rsp_p_in.life != '0);
         if (rsp_p_in.life != '0) begin
            rsp_out_x   <= rsp_p_in.pos_x;
            rsp_out_y   <= rsp_p_in.pos_y;
            rsp_shade   <= rsp_p_in.shade;
            rsp_opacity <= rsp_p_in.alpha;
         end else begin
            rsp_out_x   <= '0;
            rsp_out_y   <= '0;
            rsp_shade   <= '0;
            rsp_opacity <= '0;
         end
      end
   end

endmodule

// ===== rtl/ppu_checker.sv =====
// ----------------------------------------------------------------------------
// ppu_checker
// Port-level checks for the particle pool, bound to the top level.
// ----------------------------------------------------------------------------
module ppu_checker
   import ppu_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic               rsp_alive,
   input logic signed [23:0] rsp_out_x,
   input logic signed [23:0] rsp_out_y,
   input logic [15:0]        rsp_shade,
   input logic [16:0]        rsp_opacity,
   input logic               rsp_last
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_rsp_in_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("item emitted outside of work");

   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_alive |-> rsp_out_x == 0 && rsp_out_y == 0 &&
                                  rsp_shade == 0 && rsp_opacity == 0)
      else $error("dead slot with nonzero fields");

   a_opacity_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_opacity <= ONE_Q16)
      else $error("opacity above one");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("item after last");

endmodule

bind particle_pool_update ppu_checker u_ppu_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_alive   (rsp_alive),
   .rsp_out_x   (rsp_out_x),
   .rsp_out_y   (rsp_out_y),
   .rsp_shade   (rsp_shade),
   .rsp_opacity (rsp_opacity),
   .rsp_last    (rsp_last)
);

// ===== sim/particle_pool_update_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_pool_update_tb
// Self-checking bench for the particle pool: spawn and tick items are driven
// with random gaps, each result is checked against an in-bench pool model,
// and both registers are swept through several settings between phases.
// ----------------------------------------------------------------------------
module particle_pool_update_tb;
   import ppu_pkg::*;

   typedef struct {
      logic              func;
      logic [15:0]       dt;
      logic signed [23:0] ex, ey, sx, sy, hx, hy;
      logic [6:0]        jc, sc;
   } pool_item_type;

   typedef struct {
      logic [5:0]        slot;
      logic              alive;
      logic signed [23:0] x, y;
      logic [15:0]       shade;
      logic [16:0]       opacity;
      logic              last;
   } slot_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_func = 1'b0;
   logic [15:0] req_dt = '0;
   logic signed [23:0] req_emit_x = '0, req_emit_y = '0;
   logic signed [23:0] req_speed_x = '0, req_speed_y = '0;
   logic signed [23:0] req_shift_x = '0, req_shift_y = '0;
   logic [6:0] req_jitter_code = '0, req_shade_code = '0;
   logic rsp_valid, rsp_alive, rsp_last;
   logic [5:0] rsp_slot;
   logic signed [23:0] rsp_out_x, rsp_out_y;
   logic [15:0] rsp_shade;
   logic [16:0] rsp_opacity;
   logic csr_we = 1'b0;
   logic csr_index = CSR_FADE_RATE;
   logic [15:0] csr_data = '0;

   particle_pool_update dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // model state
   logic [16:0] life_q [PARTICLES];
   logic signed [23:0] pos_q [PARTICLES][2];
   logic signed [23:0] vel_q [PARTICLES][2];
   logic [15:0] shade_q [PARTICLES];
   logic [16:0] alpha_q [PARTICLES];
   logic [5:0] scan_from;
   logic [11:0] fade_q;
   logic [15:0] vscale_q;

   pool_item_type pending_items[$];
   slot_report_type expected_reports[$];
   int errors = 0;
   int n_spawn = 0, n_tick = 0, n_reports = 0, n_full = 0;
   bit took = 1'b0;
   bit quiet = 1'b0;

   function automatic logic signed [23:0] clamp24(longint v);
      if (v > 8388607) return 24'sd8388607;
      if (v < -8388608) return -24'sd8388608;
      return v[23:0];
   endfunction

   function automatic slot_report_type report_of(int i, bit is_last);
      slot_report_type r;
      bit al;
      al = life_q[i] != 0;
      r.slot = i[5:0];
      r.alive = al;
      r.x = al ? pos_q[i][0] : '0;
      r.y = al ? pos_q[i][1] : '0;
      r.shade = al ? shade_q[i] : '0;
      r.opacity = al ? alpha_q[i] : '0;
      r.last = is_last;
      return r;
   endfunction

   task automatic apply_item(pool_item_type it);
      int pick;
      bit found;
      longint jit, loss, stp;
      longint e[2], s[2], h[2];
      pick = 0;
      found = 0;
      if (it.func == FUNC_SPAWN) begin
         n_spawn++;
         for (int k = 0; k < PARTICLES && !found; k++) begin
            if (life_q[(scan_from + k) % PARTICLES] == 0) begin
               pick = (scan_from + k) % PARTICLES;
               found = 1;
            end
         end
         if (!found) n_full++;
         scan_from = pick[5:0];
         jit = (longint'(it.jc) * 256 + 5) / 10 - 1280;
         e[0] = it.ex; e[1] = it.ey;
         s[0] = it.sx; s[1] = it.sy;
         h[0] = it.hx; h[1] = it.hy;
         for (int a = 0; a < 2; a++) begin
            pos_q[pick][a] = clamp24(e[a] + jit + h[a]);
            vel_q[pick][a] = clamp24((s[a] * longint'(vscale_q) + 32768) >>> 16);
         end
         shade_q[pick] = 16'(16384 + (longint'(it.sc) * 32768 + 50) / 100);
         alpha_q[pick] = ONE_Q16;
         life_q[pick] = ONE_Q16;
         expected_reports.insert(expected_reports.size(), report_of(pick, 1'b1));
      end else begin
         n_tick++;
         loss = (longint'(it.dt) * longint'(fade_q) + 128) >> 8;
         for (int i = 0; i < PARTICLES; i++) begin
            life_q[i] = life_q[i] > it.dt ? life_q[i] - it.dt : '0;
            if (life_q[i] != 0) begin
               for (int a = 0; a < 2; a++) begin
                  stp = (longint'(vel_q[i][a]) * longint'(it.dt) + 32768) >>> 16;
                  pos_q[i][a] = clamp24(longint'(pos_q[i][a]) - stp);
               end
               alpha_q[i] = alpha_q[i] > loss ? 17'(alpha_q[i] - loss) : '0;
            end
            expected_reports.insert(expected_reports.size(),
                                    report_of(i, i == PARTICLES - 1));
         end
      end
   endtask

   // driver
   always @(negedge clock) begin
      pool_item_type it;
      if (!reset && (!start || took)) begin
         took = 1'b0;
         if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= 15)) begin
            it = pending_items.pop_front();
            req_func <= it.func;
            req_dt <= it.dt;
            req_emit_x <= it.ex;
            req_emit_y <= it.ey;
            req_speed_x <= it.sx;
            req_speed_y <= it.sy;
            req_shift_x <= it.hx;
            req_shift_y <= it.hy;
            req_jitter_code <= it.jc;
            req_shade_code <= it.sc;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check results, then model the item accepted at this edge
   always @(posedge clock) begin
      slot_report_type x;
      pool_item_type it;
      if (!reset) begin
         if (rsp_valid) begin
            n_reports++;
            if (expected_reports.size() == 0) begin
               $error("unexpected result, slot %0d", rsp_slot);
               errors++;
            end else begin
               x = expected_reports.pop_front();
               if (rsp_slot !== x.slot) begin
                  $error("slot: expected %0d got %0d", x.slot, rsp_slot); errors++;
               end
               if (rsp_alive !== x.alive) begin
                  $error("alive: expected %0d got %0d", x.alive, rsp_alive); errors++;
               end
               if (rsp_out_x !== x.x) begin
                  $error("out_x: expected %0d got %0d", x.x, rsp_out_x); errors++;
               end
               if (rsp_out_y !== x.y) begin
                  $error("out_y: expected %0d got %0d", x.y, rsp_out_y); errors++;
               end
               if (rsp_shade !== x.shade) begin
                  $error("shade: expected %0d got %0d", x.shade, rsp_shade); errors++;
               end
               if (rsp_opacity !== x.opacity) begin
                  $error("opacity: expected %0d got %0d", x.opacity, rsp_opacity);
                  errors++;
               end
               if (rsp_last !== x.last) begin
                  $error("last: expected %0d got %0d", x.last, rsp_last); errors++;
               end
            end
         end
         if (start && !busy) begin
            took = 1'b1;
            it.func = req_func; it.dt = req_dt;
            it.ex = req_emit_x; it.ey = req_emit_y;
            it.sx = req_speed_x; it.sy = req_speed_y;
            it.hx = req_shift_x; it.hy = req_shift_y;
            it.jc = req_jitter_code; it.sc = req_shade_code;
            apply_item(it);
         end
      end
   end

   function automatic pool_item_type make_item(logic func, logic [15:0] dt);
      pool_item_type it;
      it.func = func;
      it.dt = dt;
      it.ex = 24'($urandom); it.ey = 24'($urandom);
      it.sx = 24'($urandom); it.sy = 24'($urandom);
      it.hx = 24'($urandom); it.hy = 24'($urandom);
      it.jc = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 100))
                                       : 7'($urandom_range(99));
      it.sc = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 100))
                                       : 7'($urandom_range(99));
      return it;
   endfunction

   task automatic settle();
      do @(posedge clock);
      while (pending_items.size() != 0 || start || busy || expected_reports.size() != 0);
      repeat (PARTICLES + 8) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_data <= val;
      if (idx == CSR_FADE_RATE) fade_q = val[11:0];
      else vscale_q = val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // random phase: mostly spawns, ticks with dt up to dt_max and now and then a fully random dt
   task automatic random_phase(int count, int tick_pct, logic [15:0] dt_max);
      logic [15:0] d;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < tick_pct) begin
            d = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(dt_max));
            pending_items.insert(pending_items.size(), make_item(FUNC_TICK, d));
         end else begin
            pending_items.insert(pending_items.size(), make_item(FUNC_SPAWN, '0));
         end
      end
   endtask

   initial begin
      pool_item_type it;
      for (int i = 0; i < PARTICLES; i++) life_q[i] = '0;
      scan_from = '0;
      fade_q = FADE_RESET;
      vscale_q = VSCALE_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes of positions and codes, tick edge cases
      it = make_item(FUNC_SPAWN, '0);
      it.ex = 24'sh7fffff; it.ey = -24'sh800000; it.hx = 24'sh7fffff; it.hy = -24'sh800000;
      it.sx = 24'sh7fffff; it.sy = -24'sh800000; it.jc = 7'd99; it.sc = 7'd0;
      pending_items.insert(pending_items.size(), it);
      it.ex = -24'sh800000; it.ey = 24'sh7fffff; it.hx = -24'sh800000; it.hy = 24'sh7fffff;
      it.jc = 7'd0; it.sc = 7'd99;
      pending_items.insert(pending_items.size(), it);
      it.ex = '0; it.ey = '0; it.hx = '0; it.hy = '0; it.jc = 7'd127; it.sc = 7'd127;
      pending_items.insert(pending_items.size(), it);
      it.jc = 7'd50; it.sc = 7'd50; it.sx = '0; it.sy = '0;
      pending_items.insert(pending_items.size(), it);
      pending_items.insert(pending_items.size(), make_item(FUNC_TICK, 16'd0));
      pending_items.insert(pending_items.size(), make_item(FUNC_TICK, 16'd1));
      pending_items.insert(pending_items.size(), make_item(FUNC_TICK, 16'hffff));
      pending_items.insert(pending_items.size(), make_item(FUNC_SPAWN, '0));
      pending_items.insert(pending_items.size(), make_item(FUNC_TICK, 16'hffff));
      pending_items.insert(pending_items.size(), make_item(FUNC_TICK, 16'hffff));
      pending_items.insert(pending_items.size(), make_item(FUNC_SPAWN, '0));
      pending_items.insert(pending_items.size(), make_item(FUNC_TICK, 16'h8000));
      settle();

      // fast fade, full scale; enough spawns to fill the pool and wrap to slot 0
      write_reg(CSR_FADE_RATE, 16'd4095);
      write_reg(CSR_VSCALE, 16'hffff);
      random_phase(75, 8, 16'd16);
      settle();

      // no fade, zero scale, no gaps on the sender side
      write_reg(CSR_FADE_RATE, 16'd0);
      write_reg(CSR_VSCALE, 16'd0);
      quiet = 1'b1;
      pending_items.insert(pending_items.size(), make_item(FUNC_TICK, 16'hffff));
      pending_items.insert(pending_items.size(), make_item(FUNC_TICK, 16'hffff));
      random_phase(30, 30, 16'd4000);
      settle();
      quiet = 1'b0;

      write_reg(CSR_FADE_RATE, 16'($urandom_range(4095)));
      write_reg(CSR_VSCALE, 16'($urandom));
      random_phase(35, 35, 16'hffff);
      settle();

      $display("covered %0d spawns (%0d into a full pool) and %0d ticks, %0d results",
               n_spawn, n_full, n_tick, n_reports);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout");
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
